FILE: design/pmfr_pkg.sv
// ---------------------------------------------------------------------------
// pmfr_pkg
// shared constants and types of the particle sensor frame receiver
// ---------------------------------------------------------------------------
package pmfr_pkg;

    localparam int FRAME_LEN  = 32;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int CHK_POS    = 30;
    localparam int STATUS_POS = 29;
    localparam int RES_W      = 200;

    localparam logic [7:0]  FRAME_STX = 8'h02;
    localparam logic [7:0]  FRAME_ETX = 8'h03;
    localparam logic [15:0] GAP_RESET = 16'd500;
    localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } step_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  status;
        logic [15:0] count_100;
        logic [15:0] count_50;
        logic [15:0] count_25;
        logic [15:0] count_10;
        logic [15:0] count_05;
        logic [15:0] count_03;
        logic [31:0] mass_pm10;
        logic [31:0] mass_pm25;
        logic [31:0] mass_pm1;
    } frame_t;

endpackage

FILE: design/pmfr_core.sv
// ---------------------------------------------------------------------------
// pmfr_core
// frame assembly state: byte store, position, running xor, idle timer,
// and the frame check decoded from the beat being consumed
// ---------------------------------------------------------------------------
module pmfr_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  pmfr_pkg::step_t  item,
    input  logic [15:0]      gap_ticks,
    output logic             result_vld,
    output pmfr_pkg::frame_t result
);
    import pmfr_pkg::*;

    logic [7:0]       frame_store [FRAME_LEN];
    logic [POS_W-1:0] cnt_reg;
    logic [POS_W-1:0] cnt_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic [15:0]      idle_reg;
    logic [15:0]      idle_next;
    logic             gap_hit;
    logic             is_byte;
    logic [POS_W-1:0] pos;
    logic [7:0]       xor_base;
    logic             chk_ok;

    always_comb
    begin
        gap_hit  = idle_reg >= gap_ticks;
        is_byte  = item.op == OP_BYTE;
        pos      = gap_hit ? '0 : cnt_reg;
        xor_base = gap_hit ? 8'h00 : xor_reg;
        result_vld = is_byte && (pos == POS_W'(FRAME_LEN - 1));
        chk_ok = (frame_store[0] == FRAME_STX) && (item.data == FRAME_ETX)
              && (xor_base == frame_store[CHK_POS]);

        if (pos >= POS_W'(1) && pos < POS_W'(CHK_POS))
            xor_next = xor_base ^ item.data;
        else
            xor_next = xor_base;
        cnt_next = pos + POS_W'(1);

        if (idle_reg == IDLE_MAX)
            idle_next = idle_reg;
        else
            idle_next = idle_reg + 16'd1;
    end

    always_comb
    begin
        result = '0;
        if (chk_ok)
        begin
            result.ok        = 1'b1;
            result.mass_pm1  = {frame_store[4], frame_store[3], frame_store[2], frame_store[1]};
            result.mass_pm25 = {frame_store[8], frame_store[7], frame_store[6], frame_store[5]};
            result.mass_pm10 = {frame_store[12], frame_store[11], frame_store[10],
                                frame_store[9]};
            result.count_03  = {frame_store[14], frame_store[13]};
            result.count_05  = {frame_store[16], frame_store[15]};
            result.count_10  = {frame_store[18], frame_store[17]};
            result.count_25  = {frame_store[22], frame_store[21]};
            result.count_50  = {frame_store[24], frame_store[23]};
            result.count_100 = {frame_store[26], frame_store[25]};
            result.status    = frame_store[STATUS_POS];
        end
    end

    // byte store, no reset
    always_ff @(posedge clk)
    begin
        if (step_en && is_byte)
            frame_store[pos] <= item.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            xor_reg  <= '0;
            idle_reg <= '0;
        end
        else if (step_en)
        begin
            if (!is_byte)
                idle_reg <= idle_next;
            else
            begin
                idle_reg <= '0;
                if (result_vld)
                begin
                    cnt_reg <= '0;
                    xor_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_next;
                    xor_reg <= xor_next;
                end
            end
        end
    end

    a_idle_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item.op == OP_TICK && idle_reg == IDLE_MAX) |=> idle_reg == IDLE_MAX)
        else $error("idle timer wrapped");

    a_tick_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && item.op == OP_TICK) |=> $stable(cnt_reg) && $stable(xor_reg))
        else $error("tick changed frame position");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && result_vld) |=> cnt_reg == '0 && xor_reg == '0 && idle_reg == '0)
        else $error("state not cleared after frame end");

    a_end_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_vld |-> !gap_hit && cnt_reg == POS_W'(FRAME_LEN - 1))
        else $error("frame end without full frame");

endmodule

FILE: design/pm_sensor_frame_receiver.sv
// ---------------------------------------------------------------------------
// pm_sensor_frame_receiver
// receives uart bytes and time ticks, collects 32-byte stx/etx frames,
// checks the xor checksum and emits one decoded result per frame
//
// channel  dir  signals                        beat contents
// s        in   s_tvalid s_tready s_tdata/user byte or tick
// m        out  m_tvalid m_tready m_tdata/user decoded frame
// cfg      in   cfg_valid cfg_ready cfg_data   gap_ticks
//
// one beat per cycle unless a frame end stalls on m; accepted beats wait in
// in_item_reg until consumed; the frame result is on m right after that edge
// reset clears control state, gap_ticks returns to 500, store is unwritten
// a stalled result only blocks the input when the next beat ends a frame
// ---------------------------------------------------------------------------
module pm_sensor_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // rx_byte
    input  logic         s_tuser,   // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // mass_pm1, mass_pm25, mass_pm10, count_03,
                                    // count_05, count_10, count_25, count_50,
                                    // count_100, sensor_status
    output logic         m_tuser,   // frame_ok
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // gap_ticks
);
    import pmfr_pkg::*;

    logic             in_vld_reg;
    step_t            in_item_reg;
    logic             out_vld_reg;
    logic             out_ok_reg;
    logic [RES_W-1:0] out_data_reg;
    logic [15:0]      gap_reg;
    logic             proceed;
    logic             core_res_vld;
    frame_t           core_res;

    pmfr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (proceed),
        .item       (in_item_reg),
        .gap_ticks  (gap_reg),
        .result_vld (core_res_vld),
        .result     (core_res)
    );

    assign proceed   = in_vld_reg && (!core_res_vld || !out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || proceed;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tuser   = out_ok_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            gap_reg     <= GAP_RESET;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_vld_reg <= 1'b1;
            else if (proceed)
                in_vld_reg <= 1'b0;

            if (proceed && core_res_vld)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                gap_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op   <= s_tuser;
            in_item_reg.data <= s_tdata;
        end
        if (proceed && core_res_vld)
        begin
            out_ok_reg   <= core_res.ok;
            out_data_reg <= {core_res.status, core_res.count_100, core_res.count_50,
                             core_res.count_25, core_res.count_10, core_res.count_05,
                             core_res.count_03, core_res.mass_pm10, core_res.mass_pm25,
                             core_res.mass_pm1};
        end
    end

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tdata == '0)
        else $error("rejected frame carries data");

    a_no_block_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_tready)
        else $error("input stalled with empty output");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (proceed && core_res_vld) |=> m_tvalid && m_tuser == $past(core_res.ok))
        else $error("frame result not presented");

endmodule

FILE: dv/pm_sensor_frame_receiver_test.sv
// ---------------------------------------------------------------------------
// pm_sensor_frame_receiver_test
// self-checking bench for the particle sensor frame receiver: a table of
// directed frames (good, bad stx, bad etx, bad checksum, gap boundaries)
// followed by random phases at several gap_ticks settings, including the
// extremes and a zero gap; every result beat is compared field by field
// against the table's expected result for typed rows, else against an
// in-bench frame decoder
module pm_sensor_frame_receiver_test;

    import pmfr_pkg::*;

    typedef logic [FRAME_LEN-1:0][7:0] raw_frame_t;

    typedef enum logic [1:0] {PAY_FILL, PAY_RAMP, PAY_RAND} payload_e;
    typedef enum logic [1:0] {FAULT_NONE, FAULT_STX, FAULT_ETX, FAULT_SUM} fault_e;
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

    typedef struct {
        payload_e   pay;
        logic [7:0] fill;
        fault_e     fault;
        int         lead;
        int         ticks;
        int         tick_pos;
        bit         typed;
        frame_t     want;
    } row_t;

    localparam frame_t GOOD_ZERO = '{ok: 1'b1, default: '0};
    localparam frame_t GOOD_ONES = '1;
    localparam frame_t REJECTED  = '0;

    localparam int QUIET_CYCLES = 8;
    localparam int PHASE_ITEMS  = 120;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [199:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data  = '0;

    // decoder state
    logic [7:0]  held [FRAME_LEN];
    logic [5:0]  held_count  = '0;
    logic [7:0]  body_xor    = '0;
    logic [15:0] quiet_ticks = '0;
    logic [15:0] gap_limit   = GAP_RESET;

    frame_t frames_due [$];
    int     err_count  = 0;
    int     beats_sent = 0;
    int     burst_left = 0;

    rx_mode_e rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_hold = 0;

    row_t plan [9] = '{
        '{PAY_FILL, 8'h00, FAULT_NONE, 0,  0,   0,  1'b1, GOOD_ZERO},
        '{PAY_FILL, 8'hFF, FAULT_NONE, 0,  0,   0,  1'b1, GOOD_ONES},
        '{PAY_FILL, 8'h5A, FAULT_STX,  0,  0,   0,  1'b1, REJECTED},
        '{PAY_FILL, 8'hA5, FAULT_ETX,  0,  0,   0,  1'b1, REJECTED},
        '{PAY_RAMP, 8'h00, FAULT_SUM,  0,  0,   0,  1'b1, REJECTED},
        '{PAY_RAMP, 8'h37, FAULT_NONE, 0,  499, 16, 1'b0, REJECTED},
        '{PAY_RAMP, 8'hC3, FAULT_NONE, 10, 500, 0,  1'b0, REJECTED},
        '{PAY_FILL, 8'h11, FAULT_NONE, 0,  7,   20, 1'b0, REJECTED},
        '{PAY_RAND, 8'h00, FAULT_NONE, 0,  0,   0,  1'b0, REJECTED}
    };

    pm_sensor_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic decode_step(input step_t b, output bit done, output frame_t res);
        int pos;
        done = 1'b0;
        res  = '0;
        if (b.op == OP_TICK)
        begin
            if (quiet_ticks != IDLE_MAX)
                quiet_ticks++;
        end
        else
        begin
            if (quiet_ticks >= gap_limit)
            begin
                held_count = '0;
                body_xor   = '0;
            end
            quiet_ticks = '0;
            pos = int'(held_count);
            held[pos] = b.data;
            if (pos >= 1 && pos < CHK_POS)
                body_xor ^= b.data;
            held_count = 6'(pos + 1);
            if (held_count == FRAME_LEN)
            begin
                done = 1'b1;
                if (held[0] == FRAME_STX && held[FRAME_LEN-1] == FRAME_ETX &&
                    body_xor == held[CHK_POS])
                begin
                    res.ok        = 1'b1;
                    res.mass_pm1  = {held[4], held[3], held[2], held[1]};
                    res.mass_pm25 = {held[8], held[7], held[6], held[5]};
                    res.mass_pm10 = {held[12], held[11], held[10], held[9]};
                    res.count_03  = {held[14], held[13]};
                    res.count_05  = {held[16], held[15]};
                    res.count_10  = {held[18], held[17]};
                    res.count_25  = {held[22], held[21]};
                    res.count_50  = {held[24], held[23]};
                    res.count_100 = {held[26], held[25]};
                    res.status    = held[STATUS_POS];
                end
                held_count = '0;
                body_xor   = '0;
            end
        end
    endtask

    // sender: bursts of random length separated by random gaps
    task automatic put_beat(input step_t b, input bit typed, input frame_t want);
        bit     done;
        frame_t res;
        int     idle;
        decode_step(b, done, res);
        if (done)
            frames_due = {frames_due, (typed ? want : res)};
        if (burst_left == 0)
        begin
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.op;
        s_tdata  <= b.data;
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] d);
        put_beat(step_t'{op: OP_BYTE, data: d}, 1'b0, REJECTED);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            put_beat(step_t'{op: OP_TICK, data: 8'($urandom)}, 1'b0, REJECTED);
    endtask

    // bring the decoder back to the start of a frame
    task automatic realign(input bit by_ticks);
        int n;
        n = FRAME_LEN - int'(held_count);
        if (held_count != 0)
        begin
            if (by_ticks)
                send_ticks(int'(gap_limit));
            else
                repeat (n) send_byte(8'($urandom));
        end
    endtask

    function automatic raw_frame_t build_frame(input payload_e pay, input logic [7:0] fill,
                                               input fault_e fault);
        raw_frame_t f;
        logic [7:0] sum;
        sum  = '0;
        f[0] = FRAME_STX;
        for (int i = 1; i < CHK_POS; i++)
        begin
            case (pay)
                PAY_FILL: f[i] = fill;
                PAY_RAMP: f[i] = 8'(i) + fill;
                default:  f[i] = 8'($urandom);
            endcase
            sum ^= f[i];
        end
        f[CHK_POS]     = sum;
        f[FRAME_LEN-1] = FRAME_ETX;
        case (fault)
            FAULT_STX: f[0] = FRAME_ETX;
            FAULT_ETX: f[FRAME_LEN-1] = FRAME_STX;
            FAULT_SUM: f[CHK_POS] = ~sum;
            default: ;
        endcase
        return f;
    endfunction

    task automatic send_frame(input raw_frame_t f, input int tick_pos, input int ticks,
                              input bit typed, input frame_t want);
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            if (i == tick_pos)
                send_ticks(ticks);
            put_beat(step_t'{op: OP_BYTE, data: f[i]}, typed && i == FRAME_LEN - 1, want);
        end
    endtask

    // wait for the block to drain before touching gap_ticks
    task automatic settle();
        s_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gap_limit = v;
    endtask

    task automatic run_phase(input logic [15:0] gap, input int quota);
        int         first;
        int         pos;
        int         k;
        int         bp;
        int         bb;
        raw_frame_t f;
        settle();
        write_gap(gap);
        if (gap != 0 && gap <= 1000)
            send_ticks(int'(gap) - 1 + int'($urandom_range(0, 2)));
        first = beats_sent;
        while (beats_sent - first < quota)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    put_beat(step_t'{op: 1'($urandom_range(0, 1)), data: 8'($urandom)},
                             1'b0, REJECTED);
            end
            else
            begin
                realign(gap_limit <= 64);
                f = build_frame(($urandom_range(0, 7) == 0) ? PAY_FILL : PAY_RAND,
                                $urandom_range(0, 1) ? 8'hFF : 8'h00, FAULT_NONE);
                if ($urandom_range(0, 3) == 0)
                begin
                    bp = $urandom_range(0, FRAME_LEN - 1);
                    bb = $urandom_range(0, 7);
                    f[bp][bb] = ~f[bp][bb];
                end
                pos = $urandom_range(1, FRAME_LEN - 1);
                k   = 0;
                if (gap_limit > 1 && $urandom_range(0, 2) == 0)
                    k = $urandom_range(1, (gap_limit > 5) ? 4 : gap_limit - 1);
                else if (gap_limit <= 64 && $urandom_range(0, 19) == 0)
                    k = int'(gap_limit);
                send_frame(f, pos, k, 1'b0, REJECTED);
            end
        end
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_left % 4 == 0);
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    rx_hold = $urandom_range(1, 25);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            err_count++;
            if (err_count <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        frame_t got;
        frame_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser, m_tdata};
            if (frames_due.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat, ok %0b", m_tuser);
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("frame_ok", 32'(want.ok), 32'(got.ok));
                check_field("mass_pm1", want.mass_pm1, got.mass_pm1);
                check_field("mass_pm25", want.mass_pm25, got.mass_pm25);
                check_field("mass_pm10", want.mass_pm10, got.mass_pm10);
                check_field("count_03", 32'(want.count_03), 32'(got.count_03));
                check_field("count_05", 32'(want.count_05), 32'(got.count_05));
                check_field("count_10", 32'(want.count_10), 32'(got.count_10));
                check_field("count_25", 32'(want.count_25), 32'(got.count_25));
                check_field("count_50", 32'(want.count_50), 32'(got.count_50));
                check_field("count_100", 32'(want.count_100), 32'(got.count_100));
                check_field("sensor_status", 32'(want.status), 32'(got.status));
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames at the reset gap setting
        foreach (plan[r])
        begin
            realign(1'b0);
            repeat (plan[r].lead) send_byte(8'($urandom));
            send_frame(build_frame(plan[r].pay, plan[r].fill, plan[r].fault),
                       plan[r].tick_pos, plan[r].ticks, plan[r].typed, plan[r].want);
        end

        run_phase(16'd1, PHASE_ITEMS);
        run_phase(IDLE_MAX, PHASE_ITEMS);
        run_phase(16'($urandom_range(2, 40)), PHASE_ITEMS);
        run_phase(16'($urandom_range(41, 200)), PHASE_ITEMS);
        run_phase(16'($urandom_range(1001, 65534)), PHASE_ITEMS);
        run_phase(16'd0, 60);

        settle();
        if (err_count == 0 && frames_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(8 * 1000000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: pm_sensor_frame_receiver.f
design/pmfr_pkg.sv
design/pmfr_core.sv
design/pm_sensor_frame_receiver.sv
dv/pm_sensor_frame_receiver_test.sv
